// ----- sv/lvm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the looping sample voice mixer.
package lvm_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned LenW     = 13;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned VoiceW   = 3;
  localparam int unsigned OpW      = 2;
  localparam int unsigned RawAddrW = 14;

  localparam int SampleMax = 32767;
  localparam int SampleMin = -32768;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_MIX   = 2'd3
  } op_e;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  len;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] phase;
  } voice_t;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] phase;
    logic [TimeW-1:0] step;
    logic [TimeW-1:0] period;
    logic [LenW-1:0]  len;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] phase;
    logic [LenW-1:0]  offset;
  } calc_rsp_t;

  typedef struct packed {
    logic                start;
    logic                wr;
    logic [RawAddrW-1:0] addr;
    logic [SampleW-1:0]  data;
  } mem_req_t;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] rdata;
  } mem_rsp_t;

endpackage

// ----- sv/lvm_in_if.sv -----
`timescale 1ns / 1ps
// Input word channel of the looping sample voice mixer.
interface lvm_in_if;
  import lvm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic [VoiceW-1:0]        voice;
  logic [AddrW-1:0]         address;
  logic signed [SampleW-1:0] sample_value;
  logic [LenW-1:0]          table_length;
  logic [TimeW-1:0]         loop_period;

  modport source (
    output valid, op, voice, address, sample_value, table_length, loop_period,
    input  ready
  );

  modport sink (
    input  valid, op, voice, address, sample_value, table_length, loop_period,
    output ready
  );
endinterface

// ----- sv/lvm_out_if.sv -----
`timescale 1ns / 1ps
// Output word channel of the looping sample voice mixer.
interface lvm_out_if;
  import lvm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] mixed_sample;
  logic                      clipped;

  modport source (
    output valid, mixed_sample, clipped,
    input  ready
  );

  modport sink (
    input  valid, mixed_sample, clipped,
    output ready
  );
endinterface

// ----- sv/lvm_voice_calc.sv -----
`timescale 1ns / 1ps
// Bit-serial phase wrap and table offset divider for one voice.
module lvm_voice_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lvm_pkg::calc_req_t req_i,
  output lvm_pkg::calc_rsp_t rsp_o
);
  import lvm_pkg::*;

  localparam int unsigned SumW = TimeW + 1;
  localparam int unsigned CntW = $clog2(SumW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_DBL,
    S_ADD,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [TimeW-1:0] per_q, per_d;
  logic [TimeW-1:0] ph_q, ph_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [SumW-1:0]  trial;
  logic [SumW:0]    diff;
  logic             fits;
  logic [TimeW-1:0] rem_next;

  always_comb begin
    case (state_q)
      S_WRAP:  trial = {rem_q, sum_q[SumW-1]};
      S_DBL:   trial = {rem_q, 1'b0};
      S_ADD: begin
        if (len_q[LenW-1]) begin
          trial = {1'b0, rem_q} + {1'b0, ph_q};
        end else begin
          trial = {1'b0, rem_q};
        end
      end
      default: trial = '0;
    endcase
    diff     = {1'b0, trial} - {2'b00, per_q};
    fits     = ~diff[SumW];
    rem_next = fits ? diff[TimeW-1:0] : trial[TimeW-1:0];
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    per_d   = per_q;
    ph_d    = ph_q;
    len_d   = len_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          per_d = req_i.period;
          len_d = req_i.len;
          sum_d = {1'b0, req_i.phase} + {1'b0, req_i.step};
          rem_d = '0;
          quo_d = '0;
          cnt_d = CntW'(SumW);
          if (req_i.period == '0) begin
            ph_d    = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        rem_d = rem_next;
        sum_d = {sum_q[SumW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          ph_d    = rem_next;
          rem_d   = '0;
          cnt_d   = CntW'(LenW);
          state_d = S_DBL;
        end
      end
      S_DBL: begin
        rem_d   = rem_next;
        quo_d   = {quo_q[LenW-2:0], fits};
        state_d = S_ADD;
      end
      S_ADD: begin
        rem_d = rem_next;
        quo_d = quo_q + LenW'(fits);
        len_d = {len_q[LenW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DBL;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q   <= '0;
      rem_q   <= '0;
      per_q   <= '0;
      ph_q    <= '0;
      len_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      rem_q   <= rem_d;
      per_q   <= per_d;
      ph_q    <= ph_d;
      len_q   <= len_d;
      quo_q   <= quo_d;
      cnt_q   <= cnt_d;
    end
  end

  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.phase  = ph_q;
  assign rsp_o.offset = quo_q;
endmodule

// ----- sv/lvm_sample_mem.sv -----
`timescale 1ns / 1ps
// Sample memory with a bit-serial address reduction modulo its depth.
module lvm_sample_mem #(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lvm_pkg::mem_req_t req_i,
  output lvm_pkg::mem_rsp_t rsp_o
);
  import lvm_pkg::*;

  localparam int unsigned AW   = $clog2(MEM_DEPTH);
  localparam int unsigned RW   = AW + 1;
  localparam int unsigned CntW = $clog2(RawAddrW + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED,
    S_ACC,
    S_DONE
  } state_e;

  logic [SampleW-1:0]  mem_q [MEM_DEPTH];
  logic [SampleW-1:0]  rdata_q;

  state_e              state_q, state_d;
  logic [RawAddrW-1:0] raw_q, raw_d;
  logic [AW-1:0]       rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                wr_q, wr_d;
  logic [SampleW-1:0]  data_q, data_d;

  logic [RW-1:0]       trial;
  logic [RW-1:0]       rem_next;

  always_comb begin
    trial    = {rem_q, raw_q[RawAddrW-1]};
    rem_next = (trial >= RW'(MEM_DEPTH)) ? trial - RW'(MEM_DEPTH) : trial;
  end

  always_comb begin
    state_d = state_q;
    raw_d   = raw_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    wr_d    = wr_q;
    data_d  = data_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          raw_d   = req_i.addr;
          rem_d   = '0;
          cnt_d   = CntW'(RawAddrW);
          wr_d    = req_i.wr;
          data_d  = req_i.data;
          state_d = S_RED;
        end
      end
      S_RED: begin
        rem_d = rem_next[AW-1:0];
        raw_d = {raw_q[RawAddrW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      raw_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      wr_q    <= 1'b0;
      data_q  <= '0;
    end else begin
      state_q <= state_d;
      raw_q   <= raw_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      wr_q    <= wr_d;
      data_q  <= data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ACC) begin
      if (wr_q) begin
        mem_q[rem_q] <= data_q;
      end else begin
        rdata_q <= mem_q[rem_q];
      end
    end
  end

  assign rsp_o.done  = (state_q == S_DONE);
  assign rsp_o.rdata = rdata_q;
endmodule

// ----- sv/looping_sample_voice_mixer.sv -----
`timescale 1ns / 1ps
// Top level of the looping sample voice mixer.
//
// Input words arrive on item_i (valid/ready); each carries an op: write one
// sample memory word, start a voice, stop a voice, or mix one output sample.
// Only a mix word gives a result word on result_o (valid/ready). The phase
// step is written through time_step_we_i / time_step_i; the user must write it
// only while the block idles, as the block itself does not enforce this.
// Start and stop are handled in the idle state; a memory write runs the
// bit-serial address reduction, one address bit a cycle. A mix scans every
// voice and, for each active one, runs the phase wrap and the table offset
// in the bit-serial divider, then the address reduction and the registered
// memory read, with hand-offs between units. Words are handled one at a time.
// The result sits in an output register, so new words are taken while it
// waits; a following mix holds in its final state until the receiver takes
// the earlier result, and item_i.ready stays low meanwhile.
// Reset stops all voices and sets the phase step to 1; the sample memory is
// not cleared and must be written before it is read.
module looping_sample_voice_mixer #(
  parameter int unsigned VOICES    = 8,
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lvm_in_if.sink                  item_i,
  lvm_out_if.source               result_o,
  input  logic                    time_step_we_i,
  input  logic [lvm_pkg::TimeW-1:0] time_step_i
);
  import lvm_pkg::*;

  localparam int unsigned VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned VCW  = $clog2(VOICES + 1);
  localparam int unsigned AccW = SampleW + $clog2(VOICES) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEMW,
    S_SCAN,
    S_VRD,
    S_CALC,
    S_MEMR,
    S_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [VOICES-1:0]     active_q, active_d;
  logic [TimeW-1:0]      step_q;
  logic [VCW-1:0]        vidx_q, vidx_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                  out_valid_q, out_valid_d;
  logic [SampleW-1:0]    mix_q, mix_d;
  logic                  clip_q, clip_d;
  calc_req_t             calc_req_q, calc_req_d;
  mem_req_t              mem_req_q, mem_req_d;
  calc_rsp_t             calc_rsp;
  mem_rsp_t              mem_rsp;

  voice_t                vtab_q [VOICES];
  voice_t                vt_rdata_q;
  logic                  vt_we;
  logic [VW-1:0]         vt_waddr;
  voice_t                vt_wdata;

  logic                  accept;
  logic                  voice_ok;
  logic [VW-1:0]         vidx;
  op_e                   op;

  assign accept   = item_i.valid & item_i.ready;
  assign voice_ok = (32'(item_i.voice) < VOICES);
  assign vidx     = vidx_q[VW-1:0];
  assign op       = op_e'(item_i.op);

  always_comb begin
    state_d          = state_q;
    active_d         = active_q;
    vidx_d           = vidx_q;
    acc_d            = acc_q;
    out_valid_d      = out_valid_q;
    mix_d            = mix_q;
    clip_d           = clip_q;
    calc_req_d       = calc_req_q;
    calc_req_d.start = 1'b0;
    mem_req_d        = mem_req_q;
    mem_req_d.start  = 1'b0;
    vt_we            = 1'b0;
    vt_waddr         = vidx;
    vt_wdata         = vt_rdata_q;

    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_WRITE: begin
              mem_req_d.start = 1'b1;
              mem_req_d.wr    = 1'b1;
              mem_req_d.addr  = RawAddrW'(item_i.address);
              mem_req_d.data  = item_i.sample_value;
              state_d         = S_MEMW;
            end
            OP_START: begin
              if (voice_ok) begin
                vt_we           = 1'b1;
                vt_waddr        = VW'(item_i.voice);
                vt_wdata.base   = item_i.address;
                vt_wdata.len    = item_i.table_length;
                vt_wdata.period = item_i.loop_period;
                vt_wdata.phase  = '0;
                active_d[VW'(item_i.voice)] = 1'b1;
              end
            end
            OP_STOP: begin
              if (voice_ok) begin
                active_d[VW'(item_i.voice)] = 1'b0;
              end
            end
            OP_MIX: begin
              acc_d   = '0;
              vidx_d  = '0;
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MEMW: begin
        if (mem_rsp.done) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (vidx_q == VCW'(VOICES)) begin
          state_d = S_FIN;
        end else if (active_q[vidx]) begin
          state_d = S_VRD;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      S_VRD: begin
        calc_req_d.start  = 1'b1;
        calc_req_d.phase  = vt_rdata_q.phase;
        calc_req_d.step   = step_q;
        calc_req_d.period = vt_rdata_q.period;
        calc_req_d.len    = vt_rdata_q.len;
        state_d           = S_CALC;
      end
      S_CALC: begin
        if (calc_rsp.done) begin
          vt_we           = 1'b1;
          vt_wdata.phase  = calc_rsp.phase;
          mem_req_d.start = 1'b1;
          mem_req_d.wr    = 1'b0;
          mem_req_d.addr  = RawAddrW'(vt_rdata_q.base) + RawAddrW'(calc_rsp.offset);
          state_d         = S_MEMR;
        end
      end
      S_MEMR: begin
        if (mem_rsp.done) begin
          acc_d   = acc_q + AccW'($signed(mem_rsp.rdata));
          vidx_d  = vidx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        if (!result_o.valid || result_o.ready) begin
          out_valid_d = 1'b1;
          if (acc_q > AccW'(SampleMax)) begin
            mix_d  = SampleW'(SampleMax);
            clip_d = 1'b1;
          end else if (acc_q < AccW'(SampleMin)) begin
            mix_d  = SampleW'(SampleMin);
            clip_d = 1'b1;
          end else begin
            mix_d  = acc_q[SampleW-1:0];
            clip_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      step_q      <= TimeW'(1);
      vidx_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      mix_q       <= '0;
      clip_q      <= 1'b0;
      calc_req_q  <= '0;
      mem_req_q   <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      vidx_q      <= vidx_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      mix_q       <= mix_d;
      clip_q      <= clip_d;
      calc_req_q  <= calc_req_d;
      mem_req_q   <= mem_req_d;
      if (time_step_we_i) begin
        step_q <= time_step_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vt_we) begin
      vtab_q[vt_waddr] <= vt_wdata;
    end
    vt_rdata_q <= vtab_q[vidx];
  end

  lvm_voice_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (calc_req_q),
    .rsp_o  (calc_rsp)
  );

  lvm_sample_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req_q),
    .rsp_o  (mem_rsp)
  );

  assign item_i.ready          = (state_q == S_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.mixed_sample = mix_q;
  assign result_o.clipped      = clip_q;
endmodule
